// ----- rtl/degree_counting_sort_core_assert.svh -----
// Assertion macros for the degree counting sort core.
`ifndef DEGREE_COUNTING_SORT_CORE_ASSERT_SVH
`define DEGREE_COUNTING_SORT_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define DCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset.
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dcs_pkg.sv -----
// Package: field widths, operation codes and status codes of the degree sort core.
`default_nettype none

package dcs_pkg;

    // Fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int DEGREE_W   = 8;
    localparam int POSITION_W = 10;
    localparam int VERTEX_W   = 10;
    localparam int STATUS_W   = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes
    localparam t_opcode OP_CLEAR = 2'd0;
    localparam t_opcode OP_LOAD  = 2'd1;
    localparam t_opcode OP_SORT  = 2'd2;
    localparam t_opcode OP_READ  = 2'd3;

    // Status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_BIG      = 2'd2;
    localparam t_status ST_BAD_READ = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/degree_counting_sort_core.sv -----
// Degree counting sort core: stores vertex degrees and orders vertices by degree.
`default_nettype none

// Commands are taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with o_done high, which the receiver
// must take in that cycle. Busy time per command: a rejected load or a read that
// fails its checks never raises busy (the result is registered directly); load
// and good read make one read-modify-write of the histogram memory, or one read
// of the order memory; clear zeroes one histogram entry a cycle up to MAX_DEGREE;
// sort runs a prefix pass that reads and sums the histogram entries from degree
// 1 to MAX_DEGREE, writes the degree-0 offset, then each vertex needs a degree
// read, an offset read and the order/offset write in turn. After reset the core
// is busy while the same pass zeroes the histogram.
// Equal degrees keep load order; degrees 1 and up come first, degree 0 last.
module degree_counting_sort_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 255
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [dcs_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [dcs_pkg::DEGREE_W-1:0]   i_degree,
    input  wire logic [dcs_pkg::POSITION_W-1:0] i_position,
    output logic                                o_done,
    output logic [dcs_pkg::VERTEX_W-1:0]        o_vertex,
    output logic [dcs_pkg::STATUS_W-1:0]        o_status
);

    // Derived widths
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int DW   = $clog2(MAX_DEGREE + 1);
    localparam int DXW  = (DW > dcs_pkg::DEGREE_W) ? DW : dcs_pkg::DEGREE_W;
    localparam int PXW  = (VW > dcs_pkg::POSITION_W) ? VW : dcs_pkg::POSITION_W;
    localparam int OXW  = (VW > dcs_pkg::VERTEX_W) ? VW : dcs_pkg::VERTEX_W;
    localparam int CMPW = (PXW > CW) ? PXW : CW;
    localparam int HD   = MAX_DEGREE + 1;

    localparam logic [DXW-1:0] MAXD_X = DXW'(MAX_DEGREE);
    localparam logic [DW-1:0]  MAXD   = DW'(MAX_DEGREE);
    localparam logic [CW-1:0]  MAXV   = CW'(MAX_VERTICES);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WIPE   = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_PFX_RD = 4'd3;
    localparam logic [3:0] S_PFX_AC = 4'd4;
    localparam logic [3:0] S_PFX_Z  = 4'd5;
    localparam logic [3:0] S_PL_DS  = 4'd6;
    localparam logic [3:0] S_PL_SO  = 4'd7;
    localparam logic [3:0] S_PL_WR  = 4'd8;
    localparam logic [3:0] S_READ   = 4'd9;

    // Memories
    logic [dcs_pkg::DEGREE_W-1:0] degree_store [MAX_VERTICES];
    logic [CW-1:0]                histogram    [HD];
    logic [CW-1:0]                start_offset [HD];
    logic [VW-1:0]                sorted_order [MAX_VERTICES];

    // Control registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_sorted, n_sorted;
    logic [DW-1:0] r_d, n_d;
    logic [CW-1:0] r_v, n_v;
    logic [CW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_deg, n_deg;
    logic          r_wipe_rsp, n_wipe_rsp;
    logic          r_done, n_done;
    logic [dcs_pkg::VERTEX_W-1:0] r_vertex, n_vertex;
    logic [dcs_pkg::STATUS_W-1:0] r_status, n_status;

    // Registered read data
    logic [dcs_pkg::DEGREE_W-1:0] r_ds_q;
    logic [CW-1:0]                r_hist_q;
    logic [CW-1:0]                r_so_q;
    logic [VW-1:0]                r_ord_q;

    // Memory port controls
    logic                         ds_we;
    logic [VW-1:0]                ds_wa;
    logic [VW-1:0]                ds_ra;
    logic                         hist_we;
    logic [DW-1:0]                hist_wa;
    logic [CW-1:0]                hist_wd;
    logic [DW-1:0]                hist_ra;
    logic                         so_we;
    logic [DW-1:0]                so_wa;
    logic [CW-1:0]                so_wd;
    logic [DW-1:0]                so_ra;
    logic                         ord_we;
    logic [VW-1:0]                ord_wa;
    logic [VW-1:0]                ord_ra;

    // Index conversions
    logic [DXW-1:0]  in_deg_x;
    logic [DXW-1:0]  ds_deg_x;
    logic [PXW-1:0]  pos_x;
    logic [CMPW-1:0] pos_c;
    logic [CMPW-1:0] cnt_c;
    logic [OXW-1:0]  ord_x;
    logic [CW-1:0]   v_next;

    assign in_deg_x = DXW'(i_degree);
    assign ds_deg_x = DXW'(r_ds_q);
    assign pos_x    = PXW'(i_position);
    assign pos_c    = CMPW'(i_position);
    assign cnt_c    = CMPW'(r_count);
    assign ord_x    = OXW'(r_ord_q);
    assign v_next   = r_v + 1'b1;

    assign ds_ra  = r_v[VW-1:0];
    assign so_ra  = ds_deg_x[DW-1:0];
    assign ord_ra = pos_x[VW-1:0];
    assign ds_wa  = r_count[VW-1:0];

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_vertex = r_vertex;
    assign o_status = r_status;

    // Sequencer and prefix accumulator
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sorted   = r_sorted;
        n_d        = r_d;
        n_v        = r_v;
        n_acc      = r_acc;
        n_deg      = r_deg;
        n_wipe_rsp = r_wipe_rsp;
        n_done     = 1'b0;
        n_vertex   = '0;
        n_status   = dcs_pkg::ST_OK;
        ds_we      = 1'b0;
        hist_we    = 1'b0;
        hist_wa    = r_d;
        hist_wd    = '0;
        hist_ra    = r_d;
        so_we      = 1'b0;
        so_wa      = r_d;
        so_wd      = r_acc;
        ord_we     = 1'b0;
        ord_wa     = r_so_q[VW-1:0];

        unique case (r_state)
            S_IDLE: begin
                hist_ra = in_deg_x[DW-1:0];
                if (start) begin
                    unique case (i_opcode)
                        dcs_pkg::OP_CLEAR: begin
                            n_count    = '0;
                            n_sorted   = 1'b0;
                            n_d        = '0;
                            n_wipe_rsp = 1'b1;
                            n_state    = S_WIPE;
                        end
                        dcs_pkg::OP_LOAD: begin
                            if (r_count == MAXV) begin
                                n_done   = 1'b1;
                                n_status = dcs_pkg::ST_FULL;
                            end else if (in_deg_x > MAXD_X) begin
                                n_done   = 1'b1;
                                n_status = dcs_pkg::ST_BIG;
                            end else begin
                                ds_we   = 1'b1;
                                n_deg   = in_deg_x[DW-1:0];
                                n_state = S_LOAD;
                            end
                        end
                        dcs_pkg::OP_SORT: begin
                            n_d     = DW'(1);
                            n_acc   = '0;
                            n_state = S_PFX_RD;
                        end
                        dcs_pkg::OP_READ: begin
                            if (!r_sorted || pos_c >= cnt_c) begin
                                n_done   = 1'b1;
                                n_status = dcs_pkg::ST_BAD_READ;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Zero one histogram entry a cycle
            S_WIPE: begin
                hist_we = 1'b1;
                if (r_d == MAXD) begin
                    n_done  = r_wipe_rsp;
                    n_state = S_IDLE;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end

            // Histogram increment, count update
            S_LOAD: begin
                hist_we  = 1'b1;
                hist_wa  = r_deg;
                hist_wd  = r_hist_q + 1'b1;
                n_count  = r_count + 1'b1;
                n_sorted = 1'b0;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            S_PFX_RD: begin
                n_state = S_PFX_AC;
            end

            // Offset of this degree is the running sum
            S_PFX_AC: begin
                so_we = 1'b1;
                n_acc = r_acc + r_hist_q;
                if (r_d == MAXD) begin
                    n_state = S_PFX_Z;
                end else begin
                    n_d     = r_d + 1'b1;
                    n_state = S_PFX_RD;
                end
            end

            // Degree-0 vertices follow all others
            S_PFX_Z: begin
                so_we = 1'b1;
                so_wa = '0;
                n_v   = '0;
                if (r_count == '0) begin
                    n_sorted = 1'b1;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_PL_DS;
                end
            end

            S_PL_DS: begin
                n_state = S_PL_SO;
            end

            S_PL_SO: begin
                n_deg   = ds_deg_x[DW-1:0];
                n_state = S_PL_WR;
            end

            // Place the vertex and advance its degree's cursor
            S_PL_WR: begin
                ord_we = (r_so_q < MAXV);
                so_we  = 1'b1;
                so_wa  = r_deg;
                so_wd  = r_so_q + 1'b1;
                if (v_next == r_count) begin
                    n_sorted = 1'b1;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_v     = v_next;
                    n_state = S_PL_DS;
                end
            end

            S_READ: begin
                n_vertex = ord_x[dcs_pkg::VERTEX_W-1:0];
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the histogram sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_WIPE;
            r_count    <= '0;
            r_sorted   <= 1'b0;
            r_d        <= '0;
            r_v        <= '0;
            r_acc      <= '0;
            r_deg      <= '0;
            r_wipe_rsp <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_sorted   <= n_sorted;
            r_d        <= n_d;
            r_v        <= n_v;
            r_acc      <= n_acc;
            r_deg      <= n_deg;
            r_wipe_rsp <= n_wipe_rsp;
            r_done     <= n_done;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_vertex <= n_vertex;
        r_status <= n_status;
    end

    // Degree store
    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            degree_store[ds_wa] <= i_degree;
        end
        r_ds_q <= degree_store[ds_ra];
    end

    // Degree histogram
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            histogram[hist_wa] <= hist_wd;
        end
        r_hist_q <= histogram[hist_ra];
    end

    // Start offsets, reused as placement cursors
    always_ff @(posedge i_clk) begin
        if (so_we) begin
            start_offset[so_wa] <= so_wd;
        end
        r_so_q <= start_offset[so_ra];
    end

    // Sorted vertex order
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            sorted_order[ord_wa] <= r_v[VW-1:0];
        end
        r_ord_q <= sorted_order[ord_ra];
    end

    // Checks
`include "degree_counting_sort_core_assert.svh"
    `DCS_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while core busy")
    `DCS_ASSERT_NEXT(a_cmd_progress, start && !busy, o_done || busy, "command neither done nor running")
    `DCS_ASSERT_NOW(a_vertex_zero, o_done && (o_status != dcs_pkg::ST_OK), o_vertex == '0, "vertex nonzero on failed command")
    `DCS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAXV, "vertex count beyond store size")

endmodule

`default_nettype wire
